// ===== sv/stm_pkg.sv =====
// Shared constants, codes and types of the sparse table with row maxima.
// No dependencies; imported by the top level and the testbench.
package stm_pkg;

    // Grid geometry and stored value width
    localparam int ROW_COUNT  = 16;
    localparam int COL_COUNT  = 16;
    localparam int VALUE_BITS = 32;

    localparam int CELLS  = ROW_COUNT * COL_COUNT;
    localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int ROW_W  = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int COL_W  = (COL_COUNT > 1) ? $clog2(COL_COUNT) : 1;
    localparam int COUNT_W = $clog2(CELLS + 1);

    // Operation codes
    localparam logic [2:0] KIND_WRITE      = 3'd0;
    localparam logic [2:0] KIND_WRITE_FREE = 3'd1;
    localparam logic [2:0] KIND_READ       = 3'd2;
    localparam logic [2:0] KIND_DELETE     = 3'd3;
    localparam logic [2:0] KIND_REPORT     = 3'd4;

    // Result status codes
    localparam logic [1:0] STAT_DONE   = 2'd0;
    localparam logic [1:0] STAT_CELL   = 2'd1;
    localparam logic [1:0] STAT_REJECT = 2'd2;

    // Control sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DRAIN,
        ST_FLUSH
    } t_state;

endpackage

// ===== sv/stm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used by the top level for the cell value store.
module stm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/sparse_table_with_row_maxima.sv =====
// Sparse table with row maxima: a grid of signed cells with occupied bits.
// Busy until back in IDLE. Single-cell operations: start is registered into EXEC, which
// registers the result strobe. Report: one cell read per cycle in SCAN, then DRAIN, then
// FLUSH, which emits the final result; row results stream out during the scan. No receiver stall.
// Reset clears occupied bits and count at once; the value RAM is not reset and needs no pass.
// Depends on stm_pkg and stm_ram.
module sparse_table_with_row_maxima (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          i_kind,
    input  logic [3:0]          i_row,
    input  logic [3:0]          i_col,
    input  logic signed [31:0]  i_new_value,
    output logic                o_valid,
    output logic [1:0]          o_status,
    output logic signed [31:0]  o_read_value,
    output logic [8:0]          o_element_count,
    output logic                o_report_found,
    output logic [3:0]          o_report_row,
    output logic signed [31:0]  o_report_value,
    output logic                o_last
);

    import stm_pkg::*;

    // Flat cell index of a row and column
    function automatic logic [CELL_W-1:0] cell_index(input int row_i, input int col_i);
        int flat;
        flat = row_i * COL_COUNT + col_i;
        return flat[CELL_W-1:0];
    endfunction

    // Sequencer and operation registers
    t_state                 r_state, n_state;
    logic [2:0]             r_kind, n_kind;
    logic [CELL_W-1:0]      r_idx, n_idx;
    logic                   r_oor, n_oor;
    logic [VALUE_BITS-1:0]  r_wval, n_wval;

    // Occupancy state
    logic [CELLS-1:0]       r_occ, n_occ;
    logic [COUNT_W-1:0]     r_count, n_count;

    // Report scan counters and read stage
    logic [ROW_W-1:0]       r_row, n_row;
    logic [COL_W-1:0]       r_col, n_col;
    logic                   r_s_valid, n_s_valid;
    logic                   r_s_occ, n_s_occ;
    logic [ROW_W-1:0]       r_s_row, n_s_row;
    logic                   r_s_endrow, n_s_endrow;

    // Running row maximum and held row result
    logic                   r_have, n_have;
    logic signed [VALUE_BITS-1:0] r_best, n_best;
    logic                   r_pend_valid, n_pend_valid;
    logic [ROW_W-1:0]       r_pend_row, n_pend_row;
    logic signed [VALUE_BITS-1:0] r_pend_best, n_pend_best;

    // Output registers
    logic                   r_o_valid, n_o_valid;
    logic [1:0]             r_o_status, n_o_status;
    logic [31:0]            r_o_read_value, n_o_read_value;
    logic [COUNT_W-1:0]     r_o_count, n_o_count;
    logic                   r_o_found, n_o_found;
    logic [ROW_W-1:0]       r_o_row, n_o_row;
    logic [31:0]            r_o_report_value, n_o_report_value;
    logic                   r_o_last, n_o_last;

    // RAM port signals
    logic                   ram_we;
    logic [CELL_W-1:0]      ram_raddr;
    logic [VALUE_BITS-1:0]  ram_rdata;

    // Stage-two helpers
    logic                   hit;
    logic                   cand;
    logic                   row_have;
    logic signed [VALUE_BITS-1:0] row_best;
    logic [CELL_W-1:0]      scan_idx;

    stm_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (CELLS)
    ) u_values (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (r_wval),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign scan_idx = cell_index(int'(r_row), int'(r_col));
    assign hit      = !r_oor && r_occ[r_idx];

    // Next state, RAM control and results
    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_idx        = r_idx;
        n_oor        = r_oor;
        n_wval       = r_wval;
        n_occ        = r_occ;
        n_count      = r_count;
        n_row        = r_row;
        n_col        = r_col;
        n_s_valid    = 1'b0;
        n_s_occ      = r_s_occ;
        n_s_row      = r_s_row;
        n_s_endrow   = r_s_endrow;
        n_have       = r_have;
        n_best       = r_best;
        n_pend_valid = r_pend_valid;
        n_pend_row   = r_pend_row;
        n_pend_best  = r_pend_best;

        n_o_valid        = 1'b0;
        n_o_status       = STAT_DONE;
        n_o_read_value   = '0;
        n_o_count        = r_count;
        n_o_found        = 1'b0;
        n_o_row          = '0;
        n_o_report_value = '0;
        n_o_last         = 1'b1;

        ram_we    = 1'b0;
        ram_raddr = cell_index(int'(i_row), int'(i_col));
        busy      = 1'b1;

        // Fold the cell read issued in the previous cycle into the row maximum
        cand     = r_s_valid && r_s_occ
                   && (!r_have || (r_best < $signed(ram_rdata)));
        row_have = r_have || cand;
        row_best = cand ? $signed(ram_rdata) : r_best;
        if (r_s_valid) begin
            if (r_s_endrow) begin
                n_have = 1'b0;
                if (row_have) begin
                    // Emit the held row, hold this one until the next or the end
                    if (r_pend_valid) begin
                        n_o_valid        = 1'b1;
                        n_o_found        = 1'b1;
                        n_o_row          = r_pend_row;
                        n_o_report_value = 32'(r_pend_best);
                        n_o_last         = 1'b0;
                    end
                    n_pend_valid = 1'b1;
                    n_pend_row   = r_s_row;
                    n_pend_best  = row_best;
                end
            end else if (cand) begin
                n_have = 1'b1;
                n_best = $signed(ram_rdata);
            end
        end

        unique case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    n_kind = i_kind;
                    n_idx  = cell_index(int'(i_row), int'(i_col));
                    n_oor  = (int'(i_row) >= ROW_COUNT) || (int'(i_col) >= COL_COUNT);
                    n_wval = VALUE_BITS'(i_new_value);
                    if (i_kind == KIND_REPORT) begin
                        n_state      = ST_SCAN;
                        n_row        = '0;
                        n_col        = '0;
                        n_have       = 1'b0;
                        n_pend_valid = 1'b0;
                    end else begin
                        n_state = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                n_state   = ST_IDLE;
                n_o_valid = 1'b1;
                unique case (r_kind) inside
                    KIND_WRITE, KIND_WRITE_FREE: begin
                        if (r_oor) begin
                            n_o_status = STAT_REJECT;
                        end else if (hit && r_kind == KIND_WRITE_FREE) begin
                            n_o_status = STAT_CELL;
                        end else begin
                            ram_we       = 1'b1;
                            n_occ[r_idx] = 1'b1;
                            if (!hit) begin
                                n_count = r_count + 1'b1;
                            end
                        end
                    end
                    KIND_READ: begin
                        if (r_oor) begin
                            n_o_status = STAT_REJECT;
                        end else if (!hit) begin
                            n_o_status = STAT_CELL;
                        end else begin
                            n_o_read_value = 32'($signed(ram_rdata));
                        end
                    end
                    KIND_DELETE: begin
                        if (r_oor) begin
                            n_o_status = STAT_REJECT;
                        end else if (!hit) begin
                            n_o_status = STAT_CELL;
                        end else begin
                            n_occ[r_idx] = 1'b0;
                            n_count      = r_count - 1'b1;
                        end
                    end
                    default: begin
                        n_o_status = STAT_REJECT;
                    end
                endcase
                n_o_count = n_count;
            end
            ST_SCAN: begin
                // Issue one cell read per cycle, row by row
                ram_raddr  = scan_idx;
                n_s_valid  = 1'b1;
                n_s_occ    = r_occ[scan_idx];
                n_s_row    = r_row;
                n_s_endrow = (r_col == COL_W'(COL_COUNT - 1));
                if (r_col == COL_W'(COL_COUNT - 1)) begin
                    n_col = '0;
                    if (r_row == ROW_W'(ROW_COUNT - 1)) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FLUSH;
            end
            ST_FLUSH: begin
                // Emit the held row as the final result, or an empty result
                n_state   = ST_IDLE;
                n_o_valid = 1'b1;
                n_o_last  = 1'b1;
                if (r_pend_valid) begin
                    n_o_found        = 1'b1;
                    n_o_row          = r_pend_row;
                    n_o_report_value = 32'(r_pend_best);
                end
                n_pend_valid = 1'b0;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_occ        <= '0;
            r_count      <= '0;
            r_s_valid    <= 1'b0;
            r_have       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_occ        <= n_occ;
            r_count      <= n_count;
            r_s_valid    <= n_s_valid;
            r_have       <= n_have;
            r_pend_valid <= n_pend_valid;
            r_o_valid    <= n_o_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_kind           <= n_kind;
        r_idx            <= n_idx;
        r_oor            <= n_oor;
        r_wval           <= n_wval;
        r_row            <= n_row;
        r_col            <= n_col;
        r_s_occ          <= n_s_occ;
        r_s_row          <= n_s_row;
        r_s_endrow       <= n_s_endrow;
        r_best           <= n_best;
        r_pend_row       <= n_pend_row;
        r_pend_best      <= n_pend_best;
        r_o_status       <= n_o_status;
        r_o_read_value   <= n_o_read_value;
        r_o_count        <= n_o_count;
        r_o_found        <= n_o_found;
        r_o_row          <= n_o_row;
        r_o_report_value <= n_o_report_value;
        r_o_last         <= n_o_last;
    end

    // Drive result ports
    assign o_valid         = r_o_valid;
    assign o_status        = r_o_status;
    assign o_read_value    = $signed(r_o_read_value);
    assign o_element_count = 9'(r_o_count);
    assign o_report_found  = r_o_found;
    assign o_report_row    = 4'(r_o_row);
    assign o_report_value  = $signed(r_o_report_value);
    assign o_last          = r_o_last;

endmodule

// ===== tb/sparse_table_check.sv =====
// Scoreboard for the sparse table with row maxima: predicts every result of an
// accepted command and compares the result strobes against it, field by field.
// Depends on stm_pkg; instantiated beside the block by the tb top module.
module sparse_table_check (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic [2:0]          i_kind,
    input  logic [3:0]          i_row,
    input  logic [3:0]          i_col,
    input  logic signed [31:0]  i_new_value,
    input  logic                o_valid,
    input  logic [1:0]          o_status,
    input  logic signed [31:0]  o_read_value,
    input  logic [8:0]          o_element_count,
    input  logic                o_report_found,
    input  logic [3:0]          o_report_row,
    input  logic signed [31:0]  o_report_value,
    input  logic                o_last,
    output int unsigned         fail_count,
    output int unsigned         pending,
    output int unsigned         ops_seen,
    output int unsigned         results_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import stm_pkg::*;

    typedef struct {
        logic [1:0]                  status;
        logic signed [VALUE_BITS-1:0] read_value;
        logic [COUNT_W-1:0]          count;
        logic                        found;
        logic [ROW_W-1:0]            row;
        logic signed [VALUE_BITS-1:0] value;
        logic                        last;
    } t_table_result;

    // Own copy of the grid
    logic signed [VALUE_BITS-1:0] cell_value [CELLS];
    bit                           cell_full  [CELLS];
    int unsigned                  full_count = 0;

    t_table_result expected_results[$];

    initial begin
        fail_count   = 0;
        ops_seen     = 0;
        results_seen = 0;
        pending      = 0;
    end

    // Queue a single-cell answer, which never carries report fields
    task automatic expect_single(input logic [1:0] status,
                                 input logic signed [VALUE_BITS-1:0] rd);
        t_table_result res;
        res = '{status, rd, COUNT_W'(full_count), 1'b0, '0, '0, 1'b1};
        expected_results.push_back(res);
    endtask

    // Update the grid for one command and queue the results it causes
    task automatic apply_op(input logic [2:0] kind, input logic [3:0] row,
                            input logic [3:0] col,
                            input logic signed [VALUE_BITS-1:0] val);
        int                           idx;
        int                           last_row;
        bit                           have;
        logic signed [VALUE_BITS-1:0] best;
        t_table_result                res;
        idx = int'(row) * COL_COUNT + int'(col);
        case (kind)
            KIND_WRITE, KIND_WRITE_FREE: begin
                if (cell_full[idx] && kind == KIND_WRITE_FREE) begin
                    expect_single(STAT_CELL, '0);
                end else begin
                    if (!cell_full[idx]) full_count++;
                    cell_full[idx]  = 1'b1;
                    cell_value[idx] = val;
                    expect_single(STAT_DONE, '0);
                end
            end
            KIND_READ: begin
                if (cell_full[idx]) expect_single(STAT_DONE, cell_value[idx]);
                else expect_single(STAT_CELL, '0);
            end
            KIND_DELETE: begin
                if (cell_full[idx]) begin
                    cell_full[idx] = 1'b0;
                    full_count--;
                    expect_single(STAT_DONE, '0);
                end else begin
                    expect_single(STAT_CELL, '0);
                end
            end
            KIND_REPORT: begin
                // find the final occupied row so its result carries last
                last_row = -1;
                for (int ri = 0; ri < ROW_COUNT; ri++)
                    for (int ci = 0; ci < COL_COUNT; ci++)
                        if (cell_full[ri * COL_COUNT + ci]) last_row = ri;
                if (last_row < 0) begin
                    res = '{STAT_DONE, '0, COUNT_W'(full_count), 1'b0, '0, '0, 1'b1};
                    expected_results.push_back(res);
                end
                for (int ri = 0; ri < ROW_COUNT; ri++) begin
                    have = 1'b0;
                    best = '0;
                    // strict greater-than keeps the lowest column on a tie
                    for (int ci = 0; ci < COL_COUNT; ci++) begin
                        if (cell_full[ri * COL_COUNT + ci] &&
                            (!have || cell_value[ri * COL_COUNT + ci] > best)) begin
                            best = cell_value[ri * COL_COUNT + ci];
                            have = 1'b1;
                        end
                    end
                    if (have) begin
                        res = '{STAT_DONE, '0, COUNT_W'(full_count), 1'b1,
                                ROW_W'(ri), best, ri == last_row};
                        expected_results.push_back(res);
                    end
                end
            end
            default: expect_single(STAT_REJECT, '0);
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%h, got 0x%h", name, want, got);
            fail_count++;
        end
    endtask

    // Compare results first, then predict the transaction accepted on this edge
    always @(posedge i_clk) begin
        t_table_result want;
        if (i_rst_n) begin
            if (o_valid) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("result strobe with no result expected");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", 32'(want.status), 32'(o_status));
                    check_field("read_value", want.read_value, o_read_value);
                    check_field("element_count", 32'(want.count), 32'(o_element_count));
                    check_field("report_found", 32'(want.found), 32'(o_report_found));
                    check_field("report_row", 32'(want.row), 32'(o_report_row));
                    check_field("report_value", want.value, o_report_value);
                    check_field("last", 32'(want.last), 32'(o_last));
                end
            end
            if (start && !busy) begin
                ops_seen++;
                apply_op(i_kind, i_row, i_col, i_new_value);
            end
        end
        pending <= expected_results.size();
    end

endmodule

// ===== tb/tb.sv =====
// Top of the testbench for the sparse table with row maxima: clock, reset and
// command stimulus, verdict. Depends on stm_pkg, the block and sparse_table_check.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import stm_pkg::*;

    localparam int CYCLE_LIMIT = 600_000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [2:0]          i_kind = KIND_WRITE;
    logic [3:0]          i_row = '0;
    logic [3:0]          i_col = '0;
    logic signed [31:0]  i_new_value = '0;
    logic                o_valid;
    logic [1:0]          o_status;
    logic signed [31:0]  o_read_value;
    logic [8:0]          o_element_count;
    logic                o_report_found;
    logic [3:0]          o_report_row;
    logic signed [31:0]  o_report_value;
    logic                o_last;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned ops_seen;
    int unsigned results_seen;

    int unsigned idle_pct = 0;
    int unsigned reports_sent = 0;
    int unsigned cycle_count = 0;

    sparse_table_with_row_maxima dut (.*);

    sparse_table_check scoreboard (.*);

    always #1 i_clk = ~i_clk;

    // Watchdog: a hung block ends the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Send one command; entered and left at a falling edge
    task automatic issue(input logic [2:0] kind, input logic [3:0] row,
                         input logic [3:0] col, input logic signed [31:0] val);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start       <= 1'b1;
        i_kind      <= kind;
        i_row       <= row;
        i_col       <= col;
        i_new_value <= val;
        if (kind == KIND_REPORT) reports_sent++;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    // Favor extremes and a few small values so rows see ties
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'($urandom_range(4)) - 32'd2;
            default: return $urandom;
        endcase
    endfunction

    // Mixed traffic; most columns fall in a narrow band so cells get hit again
    task automatic random_op(input int unsigned del_pct);
        int unsigned pick;
        logic [2:0]  kind;
        logic [3:0]  row;
        logic [3:0]  col;
        pick = $urandom_range(99);
        if (pick < 3) kind = KIND_REPORT + 3'($urandom_range(3, 1));
        else if (pick < 10) kind = KIND_REPORT;
        else if (pick < 30) kind = KIND_READ;
        else if (pick < 45) kind = KIND_WRITE_FREE;
        else if (pick < 45 + del_pct) kind = KIND_DELETE;
        else kind = KIND_WRITE;
        row = 4'($urandom_range(15));
        col = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
        issue(kind, row, col, pick_value());
    endtask

    initial begin
        int cell_order [CELLS];
        int j;
        int tmp;

        // Hold reset, then release on a falling edge
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty table, extremes, occupied and absent cells, bad kinds
        idle_pct = 0;
        issue(KIND_REPORT, 4'd0, 4'd0, '0);
        issue(KIND_READ, 4'd0, 4'd0, '0);
        issue(KIND_WRITE, 4'd0, 4'd0, 32'sh7fff_ffff);
        issue(KIND_WRITE, 4'd0, 4'd15, 32'sh8000_0000);
        issue(KIND_WRITE_FREE, 4'd0, 4'd0, 32'sd5);
        issue(KIND_WRITE_FREE, 4'd15, 4'd15, 32'sh8000_0000);
        issue(KIND_WRITE, 4'd15, 4'd0, -32'sd1);
        issue(KIND_WRITE, 4'd0, 4'd0, 32'sh1234_5678);
        issue(KIND_READ, 4'd0, 4'd0, '0);
        issue(KIND_READ, 4'd0, 4'd15, '0);
        issue(KIND_REPORT, 4'd15, 4'd15, '0);
        for (int k = 1; k <= 3; k++)
            issue(KIND_REPORT + 3'(k), 4'd15, 4'd15, 32'sh7fff_ffff);
        issue(KIND_DELETE, 4'd0, 4'd0, '0);
        issue(KIND_DELETE, 4'd0, 4'd0, '0);
        issue(KIND_READ, 4'd0, 4'd0, '0);
        issue(KIND_WRITE, 4'd7, 4'd3, 32'sh5555_aaaa);
        issue(KIND_WRITE_FREE, 4'd8, 4'd12, 32'shaaaa_5555);
        issue(KIND_REPORT, 4'd0, 4'd0, '0);

        // Random mix, back to back
        repeat (120) random_op(20);

        // Fill every cell in shuffled order with the sender mostly idle
        idle_pct = 85;
        for (int i = 0; i < CELLS; i++) cell_order[i] = i;
        for (int i = CELLS - 1; i > 0; i--) begin
            j = $urandom_range(i);
            tmp = cell_order[i];
            cell_order[i] = cell_order[j];
            cell_order[j] = tmp;
        end
        for (int i = 0; i < CELLS; i++) begin
            issue($urandom_range(1) ? KIND_WRITE : KIND_WRITE_FREE,
                  4'(cell_order[i] / COL_COUNT), 4'(cell_order[i] % COL_COUNT),
                  pick_value());
            if (i % 40 == 39) issue(KIND_REPORT, 4'd0, 4'd0, '0);
        end
        issue(KIND_REPORT, 4'd0, 4'd0, '0);

        // Thin out the full table with delete-heavy traffic
        idle_pct = 29;
        repeat (80) random_op(45);

        // Let the last results arrive
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("%0d commands accepted (%0d reports), %0d results compared,",
                 ops_seen, reports_sent, results_seen);
        $display("table filled to all %0d cells, then thinned by delete-heavy traffic",
                 CELLS);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
